FILE: hdl/assert_macros.svh
// Assertion macros shared by the allocator modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: hdl/cfa_pkg.sv
// Shared types and constants for the contiguous fit allocator.
// No dependencies.
`timescale 1ns / 1ps

package cfa_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int ADDR_BITS   = 20;
    localparam int IDX_BITS    = $clog2(MAX_REGIONS);
    localparam int CNT_BITS    = $clog2(MAX_REGIONS + 1);
    localparam int SIZE_BITS   = ADDR_BITS + 1;
    localparam int ID_BITS     = 16;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [ID_BITS-1:0]   id_t;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SCAN,
        S_SHIFT,
        S_COMMIT,
        S_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture input item, clear walk index
        logic search_step;// examine entry at idx for owner match
        logic scan_step;  // examine hole before idx
        logic shift_step; // move one entry (insert or remove)
        logic commit;     // write new entry / finish
        logic step_compact;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic search_done;
        logic found;
        logic ok;         // no denial recorded so far
        logic scan_done;
        logic shift_done;
        logic [1:0] req_type;
    } stat_t;

endpackage

FILE: hdl/cfa_ctrl.sv
// Controller state machine for the contiguous fit allocator.
// Depends on cfa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  cfa_pkg::stat_t    stat,
    output cfa_pkg::cmd_t     cmd
);

    cfa_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            cfa_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = cfa_pkg::S_SEARCH;
                end
            end
            cfa_pkg::S_SEARCH:
            begin
                // owner lookup; compaction reuses the walk
                if (stat.req_type == cfa_pkg::REQ_COMPACT)
                begin
                    cmd.step_compact = 1'b1;
                    if (stat.search_done)
                        state_next = cfa_pkg::S_OUT;
                end
                else if (stat.req_type != cfa_pkg::REQ_ALLOC
                         && stat.req_type != cfa_pkg::REQ_RELEASE)
                begin
                    state_next = cfa_pkg::S_OUT;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                    if (stat.search_done)
                        state_next = cfa_pkg::S_DECIDE;
                end
            end
            cfa_pkg::S_DECIDE:
            begin
                if (stat.req_type == cfa_pkg::REQ_RELEASE)
                    state_next = stat.found ? cfa_pkg::S_SHIFT : cfa_pkg::S_OUT;
                else
                    state_next = stat.ok ? cfa_pkg::S_SCAN : cfa_pkg::S_OUT;
            end
            cfa_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = stat.found ? cfa_pkg::S_SHIFT : cfa_pkg::S_OUT;
            end
            cfa_pkg::S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done)
                    state_next = cfa_pkg::S_COMMIT;
            end
            cfa_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = cfa_pkg::S_OUT;
            end
            cfa_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = cfa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cfa_pkg::S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_out_only_in_out, clk, rst_n,
        !out_valid || state_reg == cfa_pkg::S_OUT, "result shown outside output state")
    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n,
        in_stall || state_reg == cfa_pkg::S_IDLE, "input taken while busy")
    `ASSERT_IMPL(a_load_idle, clk, rst_n,
        !cmd.load || state_reg == cfa_pkg::S_IDLE, "load outside idle")

endmodule

FILE: hdl/cfa_datapath.sv
// Datapath for the contiguous fit allocator: region table, hole scan, shifter.
// Depends on cfa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfa_pkg::cmd_t                 cmd,
    output cfa_pkg::stat_t                stat,
    input  logic                          cfg_we,
    input  logic [cfa_pkg::SIZE_BITS-1:0] cfg_data,
    input  logic [1:0]                    req_type,
    input  logic [cfa_pkg::ID_BITS-1:0]   owner_id,
    input  logic [cfa_pkg::SIZE_BITS-1:0] alloc_size,
    input  logic [1:0]                    fit_mode,
    output logic [2:0]                    status,
    output logic [cfa_pkg::ADDR_BITS-1:0] granted_base,
    output logic [cfa_pkg::CNT_BITS-1:0]  regions_in_use
);

    localparam int N = cfa_pkg::MAX_REGIONS;
    localparam int SB = cfa_pkg::SIZE_BITS;
    localparam logic [SB-1:0] SPAN = SB'(1) << cfa_pkg::ADDR_BITS;

    // Region table (flip-flops, walked one entry per cycle)
    cfa_pkg::id_t   owner_reg [N];
    cfa_pkg::addr_t base_reg  [N];
    cfa_pkg::addr_t last_reg  [N];
    cfa_pkg::cnt_t  count_reg;
    logic [SB-1:0]  msize_reg;

    logic [1:0]         type_reg;
    cfa_pkg::id_t       id_reg;
    logic [SB-1:0]      size_reg;
    logic [1:0]         mode_reg;
    cfa_pkg::cnt_t      walk_reg;
    cfa_pkg::cnt_t      pick_reg;
    logic               found_reg;
    logic [SB-1:0]      best_reg;
    logic [SB-1:0]      next_reg;   // compaction fill pointer
    logic [2:0]         status_reg;
    cfa_pkg::addr_t     gbase_reg;

    cfa_pkg::idx_t  wi;
    logic [SB-1:0]  eff_size;
    logic [SB-1:0]  h_start;
    logic [SB-1:0]  h_end;
    logic [SB-1:0]  h_len;
    logic           h_take;
    logic [SB-1:0]  c_len;
    cfa_pkg::idx_t  pi;
    logic [SB-1:0]  new_start;

    assign wi       = walk_reg[cfa_pkg::IDX_BITS-1:0];
    assign pi       = pick_reg[cfa_pkg::IDX_BITS-1:0];
    assign eff_size = (msize_reg < SPAN) ? msize_reg : SPAN;

    // Hole before slot walk_reg
    always_comb
    begin
        h_start = (walk_reg == '0) ? '0
                : {1'b0, last_reg[cfa_pkg::IDX_BITS'(walk_reg - 1'b1)]} + SB'(1);
        h_end   = (walk_reg < count_reg) ? {1'b0, base_reg[wi]} : eff_size;
        h_len   = (h_end > h_start) ? h_end - h_start : '0;
        h_take  = (h_len >= size_reg) && (!found_reg
                  || (mode_reg == cfa_pkg::FIT_BEST && h_len < best_reg)
                  || (mode_reg == cfa_pkg::FIT_WORST && h_len > best_reg));
        c_len   = {1'b0, last_reg[wi]} - {1'b0, base_reg[wi]} + SB'(1);
        new_start = (pick_reg == '0) ? '0
                  : {1'b0, last_reg[cfa_pkg::IDX_BITS'(pick_reg - 1'b1)]} + SB'(1);
    end

    always_comb
    begin
        stat.req_type    = type_reg;
        // a hole taken in this scan cycle counts at once
        stat.found       = found_reg || (cmd.scan_step && h_take);
        stat.ok          = (status_reg == cfa_pkg::ST_OK);
        stat.search_done = (walk_reg >= count_reg)
                           || (cmd.search_step && id_reg == owner_reg[wi]);
        stat.scan_done   = (walk_reg >= count_reg)
                           || (h_take && mode_reg == cfa_pkg::FIT_FIRST);
        stat.shift_done  = (type_reg == cfa_pkg::REQ_RELEASE)
                           ? (walk_reg + 1'b1 >= count_reg)
                           : (walk_reg <= pick_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            msize_reg <= SPAN;
        end
        else
        begin
            if (cfg_we)
                msize_reg <= cfg_data;
            if (cmd.commit)
            begin
                if (type_reg == cfa_pkg::REQ_RELEASE)
                    count_reg <= count_reg - 1'b1;
                else
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Walk, decisions and table updates
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg   <= req_type;
            id_reg     <= owner_id;
            size_reg   <= alloc_size;
            mode_reg   <= fit_mode;
            walk_reg   <= '0;
            found_reg  <= 1'b0;
            next_reg   <= '0;
            status_reg <= cfa_pkg::ST_OK;
            gbase_reg  <= '0;
        end
        if (cmd.step_compact && walk_reg < count_reg)
        begin
            base_reg[wi] <= next_reg[cfa_pkg::ADDR_BITS-1:0];
            last_reg[wi] <= cfa_pkg::ADDR_BITS'(next_reg + c_len - SB'(1));
            next_reg     <= next_reg + c_len;
            walk_reg     <= walk_reg + 1'b1;
        end
        if (cmd.search_step)
        begin
            if (walk_reg < count_reg && id_reg == owner_reg[wi])
            begin
                pick_reg <= walk_reg;
            end
            else if (walk_reg < count_reg)
            begin
                walk_reg <= walk_reg + 1'b1;
            end
            if (stat.search_done)
            begin
                // decide what the lookup means for this command
                if (type_reg == cfa_pkg::REQ_RELEASE)
                begin
                    found_reg  <= walk_reg < count_reg;
                    status_reg <= (walk_reg < count_reg) ? cfa_pkg::ST_OK
                                                         : cfa_pkg::ST_NOTFOUND;
                end
                else if (walk_reg < count_reg)
                begin
                    status_reg <= cfa_pkg::ST_DUP;
                end
                else if (count_reg >= cfa_pkg::CNT_BITS'(N))
                begin
                    status_reg <= cfa_pkg::ST_FULL;
                end
                else if (size_reg == '0 || mode_reg > cfa_pkg::FIT_WORST)
                begin
                    status_reg <= cfa_pkg::ST_NOFIT;
                end
                else
                begin
                    walk_reg <= '0;   // hole scan starts at the lowest hole
                end
            end
        end
        if (cmd.scan_step)
        begin
            if (h_take)
            begin
                found_reg <= 1'b1;
                best_reg  <= h_len;
                pick_reg  <= walk_reg;
            end
            if (stat.scan_done)
            begin
                walk_reg <= count_reg;
                if (!(found_reg || h_take))
                    status_reg <= cfa_pkg::ST_NOFIT;
            end
            else
            begin
                walk_reg <= walk_reg + 1'b1;
            end
        end
        if (cmd.shift_step)
        begin
            if (type_reg == cfa_pkg::REQ_RELEASE)
            begin
                if (walk_reg + 1'b1 < count_reg)
                begin
                    owner_reg[wi] <= owner_reg[cfa_pkg::IDX_BITS'(walk_reg + 1'b1)];
                    base_reg[wi]  <= base_reg[cfa_pkg::IDX_BITS'(walk_reg + 1'b1)];
                    last_reg[wi]  <= last_reg[cfa_pkg::IDX_BITS'(walk_reg + 1'b1)];
                    walk_reg      <= walk_reg + 1'b1;
                end
            end
            else if (walk_reg > pick_reg)
            begin
                owner_reg[wi] <= owner_reg[cfa_pkg::IDX_BITS'(walk_reg - 1'b1)];
                base_reg[wi]  <= base_reg[cfa_pkg::IDX_BITS'(walk_reg - 1'b1)];
                last_reg[wi]  <= last_reg[cfa_pkg::IDX_BITS'(walk_reg - 1'b1)];
                walk_reg      <= walk_reg - 1'b1;
            end
        end
        if (cmd.commit && type_reg != cfa_pkg::REQ_RELEASE)
        begin
            owner_reg[pi] <= id_reg;
            base_reg[pi]  <= new_start[cfa_pkg::ADDR_BITS-1:0];
            last_reg[pi]  <= cfa_pkg::ADDR_BITS'(new_start + size_reg - SB'(1));
            gbase_reg     <= new_start[cfa_pkg::ADDR_BITS-1:0];
        end
    end

    assign status         = status_reg;
    assign granted_base   = gbase_reg;
    assign regions_in_use = count_reg;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n,
        count_reg <= cfa_pkg::CNT_BITS'(N), "region count beyond table depth")
    `ASSERT_IMPL(a_commit_ok, clk, rst_n,
        !cmd.commit || status_reg == cfa_pkg::ST_OK, "table change on a denied item")
    `ASSERT_IMPL(a_release_nonempty, clk, rst_n,
        !(cmd.commit && type_reg == cfa_pkg::REQ_RELEASE) || count_reg != '0,
        "release with empty table")

endmodule

FILE: hdl/contiguous_fit_allocator.sv
// Top level of the contiguous fit allocator: controller plus datapath.
// Depends on cfa_pkg, cfa_ctrl and cfa_datapath.
`timescale 1ns / 1ps

// One item is handled at a time. A request first walks the table for a
// duplicate owner (one entry per cycle), then scans the holes in address
// order (one hole per cycle), then moves the entries above the insertion
// point up one slot a cycle; a release searches and then closes the gap one
// entry a cycle; a compaction rewrites one entry a cycle. The result is
// held on the output until transferred; the next item is taken in the
// cycle after that.
module contiguous_fit_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cfa_pkg::SIZE_BITS-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [cfa_pkg::ID_BITS-1:0]   owner_id,
    input  logic [cfa_pkg::SIZE_BITS-1:0] alloc_size,
    input  logic [1:0]                    fit_mode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [cfa_pkg::ADDR_BITS-1:0] granted_base,
    output logic [cfa_pkg::CNT_BITS-1:0]  regions_in_use
);

    cfa_pkg::cmd_t  cmd;
    cfa_pkg::stat_t stat;

    cfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cfa_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .owner_id       (owner_id),
        .alloc_size     (alloc_size),
        .fit_mode       (fit_mode),
        .status         (status),
        .granted_base   (granted_base),
        .regions_in_use (regions_in_use)
    );

endmodule
